/* hw/rtl/tli_pkg.sv */
// Package for the table linear interpolator: payload types, codes and FSM states.
`default_nettype none

package tli_pkg;

    localparam int DATA_WIDTH        = 32;
    localparam int MAX_POINTS        = 256;
    localparam int INDEX_WIDTH       = 8;
    localparam int POINT_COUNT_WIDTH = 9;
    localparam int CFG_INDEX_WIDTH   = 4;
    localparam int CFG_DATA_WIDTH    = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic DIR_FORWARD  = 1'b0;
    localparam logic DIR_BACKWARD = 1'b1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POINT_COUNT      = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SEARCH_DIRECTION = 4'd1;

    typedef struct packed {
        logic                          operation;
        logic [INDEX_WIDTH-1:0]        entry_index;
        logic signed [DATA_WIDTH-1:0]  entry_x;
        logic signed [DATA_WIDTH-1:0]  entry_y;
        logic signed [DATA_WIDTH-1:0]  query_x;
    } item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  result_y;
        logic                          out_of_range;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_FETCH,
        ST_PREP,
        ST_MAG,
        ST_MUL,
        ST_DIV,
        ST_CLAMP,
        ST_SUM,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/table_linear_interpolator.sv */
// Piecewise linear interpolation table with scan search and shared iterative mul/div.
//
//  channel   signals                              direction  transaction
//  item      item_valid item_ready item           in         load entry or query
//  result    result_valid result_ready result     out        one per query
//  cfg       cfg_valid cfg_ready cfg_index cfg_data in       register write
//
// Load: written from idle. Query: a scan with one table read per cycle, then fetch,
// multiply, divide, clamp and sum; out of range and equal abscissas end early.
// Multiply takes DATA_WIDTH and divide 2*DATA_WIDTH steps of one shared adder.
// Table contents are undefined after reset; no clearing pass.
// item_ready is low while a query runs; a finished result waits in the output
// register, and a new transaction may be taken while it waits.
`default_nettype none

module table_linear_interpolator #(
    parameter int MAX_POINTS = tli_pkg::MAX_POINTS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  item_valid,
    output logic                                       item_ready,
    input  wire tli_pkg::item_t                        item,
    output logic                                       result_valid,
    input  wire logic                                  result_ready,
    output tli_pkg::result_t                           result,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tli_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [tli_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    localparam int DW = tli_pkg::DATA_WIDTH;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(2 * DW);
    localparam int PW = tli_pkg::POINT_COUNT_WIDTH;
    localparam logic [2*DW-1:0] QUO_LIMIT = (2 * DW)'(1) << (DW + 1);

    tli_pkg::state_t state_reg, state_next;

    logic [PW-1:0]         point_count_reg;
    logic                  direction_reg;

    logic [2*DW-1:0]       table_mem [MAX_POINTS];
    logic [2*DW-1:0]       rd_data_reg;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  mem_we;

    logic [AW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic signed [DW-1:0]  q_reg, q_next;
    logic signed [DW-1:0]  xa_reg, xa_next, ya_reg, ya_next;
    logic signed [DW-1:0]  xb_reg, xb_next, yb_reg, yb_next;
    logic [DW:0]           dy_reg, dy_next, dq_reg, dq_next, dx_reg, dx_next;
    logic                  neg_reg, neg_next;
    logic [DW-1:0]         mcand_reg, mcand_next;
    logic [DW-1:0]         divisor_reg, divisor_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [2*DW:0]         work_reg, work_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DW+2:0]         step_reg, step_next;
    logic signed [DW-1:0]  calc_y_reg, calc_y_next;
    logic                  calc_oor_reg, calc_oor_next;
    logic signed [DW-1:0]  res_y_reg, res_y_next;
    logic                  res_oor_reg, res_oor_next;
    logic                  out_valid_reg, out_valid_next;

    logic [31:0]           n_eff;
    logic [31:0]           n_minus1;
    logic [31:0]           n_minus2;
    logic [31:0]           idx_wide;
    logic                  idx_ok;

    logic [DW+1:0]         op_a, op_b, adder_sum;
    logic                  op_cin;

    logic signed [DW-1:0]  rd_x, rd_y;
    logic [DW:0]           dy_neg, dq_neg, dx_neg;
    logic [DW-1:0]         dy_mag, dq_mag, dx_mag;
    logic [DW:0]           y_pair_sum;
    logic [DW:0]           div_shifted;
    logic                  div_ge;
    logic [DW+1:0]         quo_clamped;
    logic [DW+2:0]         total;
    logic                  total_fits;
    logic [AW-1:0]         scan_step;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            point_count_reg <= PW'(2);
            direction_reg   <= tli_pkg::DIR_FORWARD;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tli_pkg::REG_POINT_COUNT:      point_count_reg <= cfg_data[PW-1:0];
                tli_pkg::REG_SEARCH_DIRECTION: direction_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (point_count_reg < PW'(2))
            n_eff = 32'd2;
        else if (32'(point_count_reg) > 32'(MAX_POINTS))
            n_eff = 32'(MAX_POINTS);
        else
            n_eff = 32'(point_count_reg);
    end

    assign n_minus1 = n_eff - 32'd1;
    assign n_minus2 = n_eff - 32'd2;

    assign idx_wide = 32'(item.entry_index);
    assign idx_ok   = idx_wide < 32'(MAX_POINTS);
    assign wr_addr  = idx_wide[AW-1:0];

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk) begin
        if (mem_we)
            table_mem[wr_addr] <= {item.entry_x, item.entry_y};
        rd_data_reg <= table_mem[rd_addr];
    end

    assign rd_x = rd_data_reg[2*DW-1:DW];
    assign rd_y = rd_data_reg[DW-1:0];

    // Shared adder for multiply and divide steps
    assign adder_sum = op_a + op_b + (DW + 2)'(op_cin);

    assign dy_neg = (DW + 1)'(0) - dy_reg;
    assign dq_neg = (DW + 1)'(0) - dq_reg;
    assign dx_neg = (DW + 1)'(0) - dx_reg;
    assign dy_mag = dy_reg[DW] ? dy_neg[DW-1:0] : dy_reg[DW-1:0];
    assign dq_mag = dq_reg[DW] ? dq_neg[DW-1:0] : dq_reg[DW-1:0];
    assign dx_mag = dx_reg[DW] ? dx_neg[DW-1:0] : dx_reg[DW-1:0];

    assign y_pair_sum  = {ya_reg[DW-1], ya_reg} + {yb_reg[DW-1], yb_reg};
    assign div_shifted = {rem_reg, work_reg[2*DW-1]};
    assign div_ge      = !adder_sum[DW+1];
    assign quo_clamped = (work_reg[2*DW-1:0] > QUO_LIMIT) ? QUO_LIMIT[DW+1:0]
                                                          : work_reg[DW+1:0];
    assign total       = {{3{ya_reg[DW-1]}}, ya_reg} + step_reg;
    assign total_fits  = (&total[DW+2:DW-1]) || !(|total[DW+2:DW-1]);
    assign scan_step   = (direction_reg == tli_pkg::DIR_BACKWARD) ? cmp_idx_reg - AW'(1)
                                                                  : cmp_idx_reg + AW'(1);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= tli_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        cmp_idx_reg  <= cmp_idx_next;
        q_reg        <= q_next;
        xa_reg       <= xa_next;
        ya_reg       <= ya_next;
        xb_reg       <= xb_next;
        yb_reg       <= yb_next;
        dy_reg       <= dy_next;
        dq_reg       <= dq_next;
        dx_reg       <= dx_next;
        neg_reg      <= neg_next;
        mcand_reg    <= mcand_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        work_reg     <= work_next;
        cnt_reg      <= cnt_next;
        step_reg     <= step_next;
        calc_y_reg   <= calc_y_next;
        calc_oor_reg <= calc_oor_next;
        res_y_reg    <= res_y_next;
        res_oor_reg  <= res_oor_next;
    end

    always_comb begin
        state_next     = state_reg;
        cmp_idx_next   = cmp_idx_reg;
        q_next         = q_reg;
        xa_next        = xa_reg;
        ya_next        = ya_reg;
        xb_next        = xb_reg;
        yb_next        = yb_reg;
        dy_next        = dy_reg;
        dq_next        = dq_reg;
        dx_next        = dx_reg;
        neg_next       = neg_reg;
        mcand_next     = mcand_reg;
        divisor_next   = divisor_reg;
        rem_next       = rem_reg;
        work_next      = work_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        calc_y_next    = calc_y_reg;
        calc_oor_next  = calc_oor_reg;
        res_y_next     = res_y_reg;
        res_oor_next   = res_oor_reg;
        out_valid_next = out_valid_reg && !result_ready;
        item_ready     = 1'b0;
        mem_we         = 1'b0;
        rd_addr        = cmp_idx_reg;
        op_a           = '0;
        op_b           = '0;
        op_cin         = 1'b0;

        unique case (state_reg)
            tli_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item.operation == tli_pkg::OP_LOAD)
                        mem_we = idx_ok;
                    else
                    begin
                        q_next     = item.query_x;
                        state_next = tli_pkg::ST_START;
                    end
                end
            end

            tli_pkg::ST_START:
            begin
                if (direction_reg == tli_pkg::DIR_BACKWARD)
                    rd_addr = n_minus2[AW-1:0];
                else
                    rd_addr = AW'(1);
                cmp_idx_next = rd_addr;
                state_next   = tli_pkg::ST_SCAN;
            end

            tli_pkg::ST_SCAN:
            begin
                if (rd_x >= q_reg)
                begin
                    if (direction_reg == tli_pkg::DIR_BACKWARD)
                    begin
                        xa_next = rd_x;
                        ya_next = rd_y;
                        rd_addr = cmp_idx_reg + AW'(1);
                    end
                    else
                    begin
                        xb_next = rd_x;
                        yb_next = rd_y;
                        rd_addr = cmp_idx_reg - AW'(1);
                    end
                    state_next = tli_pkg::ST_FETCH;
                end
                else if ((direction_reg == tli_pkg::DIR_BACKWARD)
                         ? (cmp_idx_reg == '0) : (cmp_idx_reg == n_minus1[AW-1:0]))
                begin
                    calc_y_next   = '0;
                    calc_oor_next = 1'b1;
                    state_next    = tli_pkg::ST_DONE;
                end
                else
                begin
                    rd_addr      = scan_step;
                    cmp_idx_next = scan_step;
                end
            end

            tli_pkg::ST_FETCH:
            begin
                if (direction_reg == tli_pkg::DIR_BACKWARD)
                begin
                    xb_next = rd_x;
                    yb_next = rd_y;
                end
                else
                begin
                    xa_next = rd_x;
                    ya_next = rd_y;
                end
                state_next = tli_pkg::ST_PREP;
            end

            tli_pkg::ST_PREP:
            begin
                dy_next    = {yb_reg[DW-1], yb_reg} - {ya_reg[DW-1], ya_reg};
                dq_next    = {q_reg[DW-1], q_reg} - {xa_reg[DW-1], xa_reg};
                dx_next    = {xb_reg[DW-1], xb_reg} - {xa_reg[DW-1], xa_reg};
                state_next = tli_pkg::ST_MAG;
            end

            tli_pkg::ST_MAG:
            begin
                calc_oor_next = 1'b0;
                if (dx_reg == '0)
                begin
                    // equal abscissas: floor of the mean
                    calc_y_next = y_pair_sum[DW:1];
                    state_next  = tli_pkg::ST_DONE;
                end
                else
                begin
                    mcand_next   = dy_mag;
                    divisor_next = dx_mag;
                    work_next    = {(DW + 1)'(0), dq_mag};
                    neg_next     = dy_reg[DW] ^ dq_reg[DW] ^ dx_reg[DW];
                    cnt_next     = '0;
                    state_next   = tli_pkg::ST_MUL;
                end
            end

            tli_pkg::ST_MUL:
            begin
                op_a      = {1'b0, work_reg[2*DW:DW]};
                op_b      = work_reg[0] ? {2'b00, mcand_reg} : '0;
                work_next = {1'b0, adder_sum[DW:0], work_reg[DW-1:1]};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1))
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = tli_pkg::ST_DIV;
                end
            end

            tli_pkg::ST_DIV:
            begin
                op_a      = {1'b0, div_shifted};
                op_b      = ~{2'b00, divisor_reg};
                op_cin    = 1'b1;
                rem_next  = div_ge ? adder_sum[DW-1:0] : div_shifted[DW-1:0];
                work_next = {1'b0, work_reg[2*DW-2:0], div_ge};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(2 * DW - 1))
                    state_next = tli_pkg::ST_CLAMP;
            end

            tli_pkg::ST_CLAMP:
            begin
                step_next  = neg_reg ? (DW + 3)'(0) - {1'b0, quo_clamped}
                                     : {1'b0, quo_clamped};
                state_next = tli_pkg::ST_SUM;
            end

            tli_pkg::ST_SUM:
            begin
                if (total_fits)
                    calc_y_next = total[DW-1:0];
                else if (total[DW+2])
                    calc_y_next = {1'b1, {(DW - 1){1'b0}}};
                else
                    calc_y_next = {1'b0, {(DW - 1){1'b1}}};
                state_next = tli_pkg::ST_DONE;
            end

            tli_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    res_y_next     = calc_y_reg;
                    res_oor_next   = calc_oor_reg;
                    out_valid_next = 1'b1;
                    state_next     = tli_pkg::ST_IDLE;
                end
            end

            default:
                state_next = tli_pkg::ST_IDLE;
        endcase
    end

    assign result_valid        = out_valid_reg;
    assign result.result_y     = res_y_reg;
    assign result.out_of_range = res_oor_reg;

    // Assertions
    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.operation == tli_pkg::OP_LOAD)
        |=> state_reg == tli_pkg::ST_IDLE)
        else $error("load transaction left idle");

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.operation == tli_pkg::OP_QUERY)
        |=> state_reg == tli_pkg::ST_START)
        else $error("query transaction did not start a scan");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tli_pkg::ST_SCAN |-> 32'(cmp_idx_reg) <= n_minus1)
        else $error("scan index beyond entries in use");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tli_pkg::ST_DIV |-> (divisor_reg != '0) && (rem_reg < divisor_reg))
        else $error("divider remainder not below divisor");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_of_range |-> result.result_y == '0)
        else $error("out of range result with nonzero value");

    a_done_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tli_pkg::ST_DONE && out_valid_reg && !result_ready)
        |=> state_reg == tli_pkg::ST_DONE)
        else $error("pending result overwritten");

endmodule

`default_nettype wire
